FILE: rtl/core/bfpv_pkg.sv
package bfpv_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int MAX_BYTES      = 5;
  localparam int CNT_W          = 3;

  typedef enum logic [1:0] {
    CMD_RAW    = 2'd0,
    CMD_VARINT = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  // Bytes produced by one command, handed to the output queue in one go
  typedef struct packed {
    logic [CNT_W-1:0]           nbytes;
    logic [MAX_BYTES-1:0][7:0]  bytes;
    logic                       byte_valid;
    logic [31:0]                total;
  } burst_t;

endpackage

FILE: rtl/core/bfpv_if.sv
interface bfpv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] value;
  logic [5:0]  count;

  modport source (output valid, output cmd, output value, output count, input ready);
  modport sink   (input valid, input cmd, input value, input count, output ready);
endinterface

interface bfpv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [31:0] total_bits;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output total_bits, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input total_bits, output ready);
endinterface

FILE: rtl/core/bfpv_pack.sv
module bfpv_pack
  import bfpv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  bfpv_in_if.sink      in_ch,
  input  logic         q_free,
  output logic         push,
  output burst_t       burst
);

  logic        ir_valid_r;
  logic [1:0]  ir_cmd_r;
  logic [31:0] ir_value_r;
  logic [5:0]  ir_count_r;

  logic [6:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic [31:0] bit_total_r, bit_total_nxt;

  logic        go;
  logic [5:0]  n_raw;
  logic [32:0] mask33;
  logic [34:0] val_ext;
  logic [2:0]  ngroups;
  logic [39:0] payload;
  logic [5:0]  nbits;
  logic [46:0] stream;
  logic [5:0]  have;
  logic [32:0] sum33;
  logic [31:0] total_sat;
  logic [6:0]  pend_after;

  assign go          = ir_valid_r && q_free;
  assign in_ch.ready = !ir_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      ir_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      ir_cmd_r   <= in_ch.cmd;
      ir_value_r <= in_ch.value;
      ir_count_r <= in_ch.count;
    end
  end

  // Build the bit payload and its length for raw or varint
  always_comb begin
    n_raw   = (ir_count_r > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : ir_count_r;
    mask33  = (33'd1 << n_raw) - 33'd1;
    val_ext = {3'b000, ir_value_r};
    if (ir_value_r[31:28] != 4'd0)      ngroups = 3'd5;
    else if (ir_value_r[27:21] != 7'd0) ngroups = 3'd4;
    else if (ir_value_r[20:14] != 7'd0) ngroups = 3'd3;
    else if (ir_value_r[13:7] != 7'd0)  ngroups = 3'd2;
    else                                ngroups = 3'd1;
    payload = '0;
    nbits   = '0;
    if (cmd_t'(ir_cmd_r) == CMD_VARINT) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
        if (3'(i) < ngroups) begin
          payload[8*i +: 8] = {(3'(i) < ngroups - 3'd1), val_ext[7*i +: 7]};
        end
      end
      nbits = {ngroups, 3'b000};
    end else begin
      payload = {8'd0, ir_value_r & mask33[31:0]};
      nbits   = n_raw;
    end
    stream    = {40'd0, pend_bits_r} | ({7'd0, payload} << pend_cnt_r);
    have      = {3'b000, pend_cnt_r} + nbits;
    sum33     = {1'b0, bit_total_r} + 33'(nbits);
    total_sat = sum33[32] ? 32'hffff_ffff : sum33[31:0];
    unique case (have[5:3])
      3'd0:    pend_after = stream[6:0];
      3'd1:    pend_after = stream[14:8];
      3'd2:    pend_after = stream[22:16];
      3'd3:    pend_after = stream[30:24];
      3'd4:    pend_after = stream[38:32];
      3'd5:    pend_after = stream[46:40];
      default: pend_after = 7'd0;
    endcase
  end

  always_comb begin
    pend_bits_nxt    = pend_bits_r;
    pend_cnt_nxt     = pend_cnt_r;
    bit_total_nxt    = bit_total_r;
    burst.nbytes     = '0;
    burst.bytes      = stream[39:0];
    burst.byte_valid = 1'b1;
    burst.total      = '0;
    unique case (cmd_t'(ir_cmd_r))
      CMD_RAW, CMD_VARINT: begin
        pend_bits_nxt = pend_after;
        pend_cnt_nxt  = have[2:0];
        bit_total_nxt = total_sat;
        burst.nbytes  = have[5:3];
      end
      CMD_FLUSH: begin
        pend_bits_nxt    = '0;
        pend_cnt_nxt     = '0;
        bit_total_nxt    = '0;
        burst.nbytes     = 3'd1;
        burst.bytes      = {32'd0, 1'b0, pend_bits_r};
        burst.byte_valid = (pend_cnt_r != 3'd0);
        burst.total      = bit_total_r;
      end
      default: begin
        // unused code: drop the item
      end
    endcase
  end

  assign push = go && (burst.nbytes != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      bit_total_r <= '0;
    end else if (go) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      bit_total_r <= bit_total_nxt;
    end
  end

endmodule

FILE: rtl/core/bfpv_outq.sv
module bfpv_outq
  import bfpv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  burst_t       burst,
  output logic         q_free,
  bfpv_out_if.source   out_ch
);

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [MAX_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic                      bv_r;
  logic [31:0]               total_r;
  logic                      pop;

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.out_byte   = bytes_r[0];
  assign out_ch.byte_valid = bv_r;
  assign out_ch.last       = (cnt_r == CNT_W'(1));
  assign out_ch.total_bits = total_r;

  assign pop    = out_ch.valid && out_ch.ready;
  // Free now, or the final beat leaves this cycle
  assign q_free = (cnt_r == '0) || (out_ch.last && out_ch.ready);

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    if (push) begin
      cnt_nxt   = burst.nbytes;
      bytes_nxt = burst.bytes;
    end else if (pop) begin
      cnt_nxt   = cnt_r - CNT_W'(1);
      bytes_nxt = {8'd0, bytes_r[MAX_BYTES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (push) begin
      bv_r    <= burst.byte_valid;
      total_r <= burst.total;
    end
  end

endmodule

FILE: rtl/core/bit_field_packer_varint.sv
// Channel   Dir  Payload                                   Beat
// in_ch     in   cmd[1:0], value[31:0], count[5:0]         one command
// out_ch    out  out_byte[7:0], byte_valid, last,          one stream byte
//                total_bits[31:0]
// A command is registered on acceptance and expanded, once the output queue is
// free, into 0..5 bytes, which leave one per cycle while out_ch is ready; the
// single byte-wide result port sets the sustained rate.
// Reset (rst_n low, synchronous) empties both stages and starts a new stream.
// A stalled out_ch holds the queue; one further command waits in the input
// register, so in_ch stays ready until that register is full.
module bit_field_packer_varint
  import bfpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bfpv_in_if.sink     in_ch,
  bfpv_out_if.source  out_ch
);

  logic   q_free;
  logic   push;
  burst_t burst;

  bfpv_pack u_pack (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_free (q_free),
    .push   (push),
    .burst  (burst)
  );

  bfpv_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .burst  (burst),
    .q_free (q_free),
    .out_ch (out_ch)
  );

endmodule
